### hw/rtl/fwsc_pkg.sv
// fwsc_pkg: shared types and constants of the four wheel speed counter
// used by fwsc_lane, fwsc_merge and four_wheel_speed_counter_top; no dependencies

package fwsc_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_EDGES_PER_TURN    = 2'd0;
   localparam logic [1:0] REG_WHEEL_DIAMETER_MM = 2'd1;
   localparam logic [1:0] REG_WINDOW_PERIOD_MS  = 2'd2;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 16;

   // 360*pi in q16, rounded
   localparam int unsigned K_BITS = 27;
   localparam logic [K_BITS-1:0] SPEED_K_Q16 = 27'd74119470;

   // denominator edges per turn * elapsed ms
   localparam int unsigned DEN_BITS = 48;

   localparam logic [15:0] SAT16 = 16'hFFFF;

   typedef struct packed {
      logic rise;    // rising edge on this lane's sensor line with an accepted item
      logic close;   // window closes with this item
   } lane_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [15:0] pulse_count;
      logic [15:0] speed;
   } lane_status_type;

endpackage

### hw/rtl/four_wheel_speed_counter_top.sv
// four_wheel_speed_counter_top: windowed pulse-count tachometer, top level
// depends on fwsc_pkg, fwsc_lane and fwsc_merge
//
// usage:
//  - req stream: one item per clock carries the sensor line levels and a
//    millisecond tick; each rising sensor edge bumps that wheel's counter
//  - rsp stream: when the window elapses, one item per wheel, wheel 1 first,
//    with pulse count, speed in 0.01 km/h and close time; tlast on the last
//  - csr port: plain write of edges per turn, wheel_diameter_mm and
//    window_period_ms; write only while no window is being computed
//  - throughput: one req item per cycle while no window closes; the item
//    that closes a window drops req_tready while the lanes run their
//    three multiply steps, divider setup and 16-step divide, plus any wait
//    for the previous batch to leave the rsp side
//  - reset (synchronous) restores register defaults, clears counters, time
//    and window start, and drops any pending results
//  - a stalled rsp side holds its item; req items keep flowing until the
//    next window closes, then wait for the batch to drain

module four_wheel_speed_counter_top #(
   parameter int CHANNELS   = 4,
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req item: [3:0] sensor_levels, [4] ms_tick, [7:5] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp item: [2:0] wheel_number, [18:3] pulse_count, [34:19] speed_centi_kph,
   // [66:35] timestamp_ms, [71:67] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   // configuration writes
   input  logic                                csr_we,
   input  logic [fwsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fwsc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import fwsc_pkg::*;

   // top sequencer codes
   localparam logic ST_RUN  = 1'b0;
   localparam logic ST_CALC = 1'b1;

   logic        state_ff, state_in;
   logic [15:0] ppv_ff, diam_ff;
   logic [9:0]  period_ff;
   logic [3:0]  prev_ff;
   logic [31:0] time_ff, time_in;
   logic [31:0] start_ff;
   logic [31:0] dt_ff, stamp_ff;
   logic [DEN_BITS-1:0] den_ff;

   logic        accept;
   logic [3:0]  levels, rising;
   logic [31:0] dt;
   logic [9:0]  period_eff;
   logic        close;
   logic        all_done;
   logic        merge_busy;
   logic        load;

   lane_ctrl_type   lane_ctrl   [CHANNELS];
   lane_status_type lane_status [CHANNELS];

   assign req_tready = state_ff == ST_RUN;
   assign accept     = req_tvalid && req_tready;
   assign levels     = req_tdata[3:0];
   assign rising     = levels & ~prev_ff;

   // window test after the tick of this item; zero period acts as one ms
   assign time_in    = time_ff + {31'b0, req_tdata[4]};
   assign dt         = time_in - start_ff;
   assign period_eff = (period_ff == '0) ? 10'd1 : period_ff;
   assign close      = accept && (dt >= {22'b0, period_eff});

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         all_done = all_done & lane_status[i].done;
      end
   end

   // hand the finished batch over once the rsp side is free
   assign load = (state_ff == ST_CALC) && all_done && !merge_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:  if (close) state_in = ST_CALC;
         ST_CALC: if (load)  state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         ppv_ff    <= 16'd20;
         diam_ff   <= 16'd300;
         period_ff <= 10'd100;
         prev_ff   <= '0;
         time_ff   <= '0;
         start_ff  <= '0;
      end else begin
         state_ff <= state_in;
         // zero writes to edges per turn and diameter are dropped
         if (csr_we) begin
            unique case (csr_index)
               REG_EDGES_PER_TURN: begin
                  if (csr_wdata != '0) ppv_ff <= csr_wdata;
               end
               REG_WHEEL_DIAMETER_MM: begin
                  if (csr_wdata != '0) diam_ff <= csr_wdata;
               end
               REG_WINDOW_PERIOD_MS: period_ff <= csr_wdata[9:0];
               default: ;
            endcase
         end
         if (accept) begin
            prev_ff <= levels;
            time_ff <= time_in;
         end
         if (close) begin
            start_ff <= time_in;
         end
      end
   end

   // window figures, no reset; den is ready long before the divide starts
   always_ff @(posedge clock) begin
      if (close) begin
         dt_ff    <= dt;
         stamp_ff <= time_in;
      end
      den_ff <= {32'b0, ppv_ff} * {16'b0, dt_ff};
   end

   // one lane per wheel; lanes beyond the four sensor lines never count
   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      if (g < 4) begin : g_rise
         assign lane_ctrl[g].rise = accept && rising[g];
      end else begin : g_norise
         assign lane_ctrl[g].rise = 1'b0;
      end
      assign lane_ctrl[g].close = close;

      fwsc_lane #(
         .COUNT_BITS (COUNT_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl[g]),
         .diameter (diam_ff),
         .den      (den_ff),
         .status   (lane_status[g])
      );
   end

   fwsc_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .timestamp   (stamp_ff),
      .lane_status (lane_status),
      .busy        (merge_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### hw/rtl/fwsc_lane.sv
// fwsc_lane: one wheel's saturating pulse counter and its speed unit
// (multiply in three steps, then a 16-step restoring divider); uses fwsc_pkg

module fwsc_lane #(
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fwsc_pkg::lane_ctrl_type       ctrl,
   input  logic [15:0]                   diameter,
   input  logic [fwsc_pkg::DEN_BITS-1:0] den,
   output fwsc_pkg::lane_status_type     status
);
   import fwsc_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_MUL0 = 3'd1;
   localparam logic [2:0] PH_MUL1 = 3'd2;
   localparam logic [2:0] PH_MUL2 = 3'd3;
   localparam logic [2:0] PH_DINIT = 3'd4;
   localparam logic [2:0] PH_DIV  = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [2:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_next;
   logic [COUNT_BITS-1:0] pulses_ff;
   logic [31:0]           pulses32;
   logic [47:0]           num_ff;
   logic [58:0]           lo_ff;
   logic [43:0]           hi_ff;
   logic [47:0]           rem_ff, rem_in;
   logic [15:0]           shift_ff, shift_in;
   logic                  sat_ff, sat_in;
   logic [3:0]            step_ff, step_in;
   logic [48:0]           trial;
   logic                  qbit;

   assign pulses32 = 32'(pulses_ff);

   // saturating edge counter
   always_comb begin
      count_next = count_ff;
      if (ctrl.rise && count_ff != COUNT_MAX) begin
         count_next = count_ff + 1'b1;
      end
      count_in = ctrl.close ? '0 : count_next;
   end

   // one restoring divide step
   always_comb begin
      trial = {rem_ff, shift_ff[15]};
      qbit  = trial >= {1'b0, den};
   end

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      sat_in   = sat_ff;
      unique case (phase_ff)
         PH_IDLE, PH_DONE: begin
            phase_in = phase_ff;
         end
         PH_MUL0: phase_in = PH_MUL1;
         PH_MUL1: phase_in = PH_MUL2;
         PH_MUL2: phase_in = PH_DINIT;
         PH_DINIT: begin
            // quotient wider than 16 bits saturates
            sat_in   = {4'b0, hi_ff} >= den;
            rem_in   = sat_in ? '0 : {4'b0, hi_ff};
            shift_in = lo_ff[31:16];
            step_in  = '0;
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            rem_in   = qbit ? 48'(trial - {1'b0, den}) : trial[47:0];
            shift_in = {shift_ff[14:0], qbit};
            step_in  = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               phase_in = PH_DONE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (ctrl.close) begin
         phase_in = PH_MUL0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (ctrl.close) begin
         pulses_ff <= count_next;
      end
      if (phase_ff == PH_MUL0) begin
         num_ff <= {16'b0, pulses32} * {32'b0, diameter};
      end
      if (phase_ff == PH_MUL1) begin
         lo_ff <= {27'b0, num_ff[31:0]} * {32'b0, SPEED_K_Q16};
      end
      if (phase_ff == PH_MUL2) begin
         hi_ff <= ({28'b0, num_ff[47:32]} * {17'b0, SPEED_K_Q16}) + {17'b0, lo_ff[58:32]};
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      sat_ff   <= sat_in;
      step_ff  <= step_in;
   end

   assign status.done        = phase_ff == PH_DONE;
   assign status.pulse_count = (|pulses32[31:16]) ? SAT16 : pulses32[15:0];
   assign status.speed       = sat_ff ? SAT16 : shift_ff;

endmodule

### hw/rtl/fwsc_merge.sv
// fwsc_merge: collects the lane results of a closed window and sends them
// out one item per wheel on the rsp stream; uses fwsc_pkg

module fwsc_merge #(
   parameter int CHANNELS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [31:0]               timestamp,
   input  fwsc_pkg::lane_status_type lane_status [CHANNELS],
   output logic                      busy,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [71:0]               rsp_tdata,
   output logic                      rsp_tlast
);
   import fwsc_pkg::*;

   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CHANNELS - 1);

   logic                busy_ff, busy_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [15:0]         count_ff [CHANNELS];
   logic [15:0]         speed_ff [CHANNELS];
   logic [31:0]         stamp_ff;
   logic                last;
   logic [3:0]          wheel_full;

   assign last = idx_ff == LAST_IDX;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff && rsp_tready) begin
         idx_in = idx_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stamp_ff <= timestamp;
         for (int i = 0; i < CHANNELS; i++) begin
            count_ff[i] <= lane_status[i].pulse_count;
            speed_ff[i] <= lane_status[i].speed;
         end
      end
   end

   // wheel numbers above seven wrap to three bits
   assign wheel_full = 4'(idx_ff) + 4'd1;

   assign busy       = busy_ff;
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {5'b0, stamp_ff, speed_ff[idx_ff], count_ff[idx_ff], wheel_full[2:0]};

endmodule

### bench/wheel_speed_checker.sv
// wheel_speed_checker: watches the req, rsp and csr ports of the wheel speed counter,
// predicts every window batch and compares each rsp item field by field
// depends on fwsc_pkg for the register indexes and csr port widths
`timescale 1ns / 100ps

module wheel_speed_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [71:0]                         rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [fwsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fwsc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  outstanding,
   output int                                  fail_count
);
   import fwsc_pkg::*;

   // 360*pi in q16
   localparam logic [26:0] KPH_K_Q16  = 27'd74119470;
   localparam logic [15:0] FIELD_SAT  = 16'hFFFF;
   localparam int          SHOW_LINES = 200;

   typedef struct packed {
      logic [2:0]  wheel;
      logic [15:0] pulses;
      logic [15:0] speed;
      logic [31:0] stamp;
      logic        last;
   } wheel_report_type;

   wheel_report_type reports_due[$];

   logic [15:0] ppr_q;
   logic [15:0] diam_q;
   logic [9:0]  period_q;
   logic [3:0]  last_levels;
   logic [31:0] pulse_tally [4];
   logic [31:0] now_ms;
   logic [31:0] window_open_ms;

   int mismatches  = 0;
   int lines_shown = 0;

   assign fail_count = mismatches;

   function automatic logic [15:0] speed_centi_kph_of(input logic [31:0] pulses,
                                                      input logic [31:0] span_ms,
                                                      input logic [15:0] ppr,
                                                      input logic [15:0] diam);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      if (ppr == 16'd0 || span_ms == 32'd0)
         return 16'd0;
      num = 128'(pulses) * 128'(diam) * 128'(KPH_K_Q16);
      den = (128'(ppr) * 128'(span_ms)) << 16;
      quo = num / den;
      return (quo > 128'(FIELD_SAT)) ? FIELD_SAT : quo[15:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatches++;
      if (lines_shown < SHOW_LINES) begin
         lines_shown++;
         $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   task automatic apply_csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                                  input logic [CSR_DATA_BITS-1:0] value);
      case (index)
         REG_EDGES_PER_TURN: begin
            if (value != '0) ppr_q = value;
         end
         REG_WHEEL_DIAMETER_MM: begin
            if (value != '0) diam_q = value;
         end
         REG_WINDOW_PERIOD_MS: begin
            period_q = value[9:0];
         end
         default: ;
      endcase
   endtask

   // count edges, advance time, then close the window if it has run its length
   task automatic predict_item(input logic [3:0] levels, input logic tick);
      logic [3:0]       rising;
      logic [31:0]      span;
      logic [31:0]      needed;
      wheel_report_type r;
      int               w;
      rising = levels & ~last_levels;
      for (w = 0; w < 4; w++)
         if (rising[w] && pulse_tally[w] != '1) pulse_tally[w]++;
      last_levels = levels;
      if (tick) now_ms++;
      needed = (period_q == '0) ? 32'd1 : 32'(period_q);
      span   = now_ms - window_open_ms;
      if (span >= needed) begin
         for (w = 0; w < 4; w++) begin
            r.wheel  = 3'(w + 1);
            r.pulses = (pulse_tally[w] > 32'(FIELD_SAT)) ? FIELD_SAT : pulse_tally[w][15:0];
            r.speed  = speed_centi_kph_of(pulse_tally[w], span, ppr_q, diam_q);
            r.stamp  = now_ms;
            r.last   = (w == 3);
            reports_due.push_back(r);
            pulse_tally[w] = '0;
         end
         window_open_ms = now_ms;
      end
   endtask

   task automatic check_result();
      wheel_report_type want;
      if (reports_due.size() == 0) begin
         report_mismatch("rsp item with nothing due, wheel", 0, rsp_tdata[2:0]);
      end else begin
         want = reports_due.pop_front();
         if (rsp_tdata[2:0] != want.wheel)
            report_mismatch("wheel_number", want.wheel, rsp_tdata[2:0]);
         if (rsp_tdata[18:3] != want.pulses)
            report_mismatch("pulse_count", want.pulses, rsp_tdata[18:3]);
         if (rsp_tdata[34:19] != want.speed)
            report_mismatch("speed_centi_kph", want.speed, rsp_tdata[34:19]);
         if (rsp_tdata[66:35] != want.stamp)
            report_mismatch("timestamp_ms", want.stamp, rsp_tdata[66:35]);
         if (rsp_tlast != want.last)
            report_mismatch("batch_end", want.last, rsp_tlast);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ppr_q          = 16'd20;
         diam_q         = 16'd300;
         period_q       = 10'd100;
         last_levels    = '0;
         now_ms         = '0;
         window_open_ms = '0;
         foreach (pulse_tally[w]) pulse_tally[w] = '0;
         reports_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_we) apply_csr_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) predict_item(req_tdata[3:0], req_tdata[4]);
      end
      outstanding <= reports_due.size();
   end

endmodule

### bench/tb.sv
// tb: stimulus and verdict for four_wheel_speed_counter_top
// depends on fwsc_pkg, the block's rtl and wheel_speed_checker
`timescale 1ns / 100ps

module tb;
   import fwsc_pkg::*;

   // csr index that maps to no register
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_ITEMS   = 200;
   localparam int RANDOM_BATCHES = 16;
   // a closing item holds req until its batch is computed and the first rsp
   // item follows, so this much quiet time means the block is done
   localparam int SETTLE_CYCLES  = 30;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [71:0]               rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   int outstanding;
   int fail_count;

   // one in idle_odds rsp cycles or req items starts an idle burst on that side, 0 turns idling off
   int idle_odds    = 0;
   int rsp_hold     = 0;
   int items_sent   = 0;
   int batches_seen = 0;
   int cycles       = 0;

   always #6 clock = ~clock;

   four_wheel_speed_counter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wheel_speed_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // rsp side stalls in random bursts
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_hold = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // finished batches, used only to decide when the random part may stop
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && rsp_tlast) batches_seen <= batches_seen + 1;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one req item; valid stays high on return so back-to-back items never
   // lower and raise it in the same step
   task automatic send_item(input logic [3:0] levels, input logic tick);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, tick, levels};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // stop the req stream, wait for every due rsp item, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after its last write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] ppr, input logic [15:0] diam,
                            input logic [15:0] period);
      drain();
      write_reg(REG_EDGES_PER_TURN, ppr);
      write_reg(REG_WHEEL_DIAMETER_MM, diam);
      write_reg(REG_WINDOW_PERIOD_MS, period);
      csr_we <= 1'b0;
   endtask

   // register values biased toward the extremes
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return 16'd1;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 400));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   initial begin
      int         i;
      int         phase;
      int         tick_odds;
      int         base_items;
      int         base_batches;
      logic [3:0] lv;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---------------- directed part ----------------
      idle_odds = 6;

      // one pulse in a 1 ms window with the largest wheel: speed saturates
      configure(16'd1, 16'hFFFF, 16'd1);
      send_item(4'hF, 1'b0);
      send_item(4'h0, 1'b1);

      // zero period acts as one ms; smallest wheel and most edges per turn
      configure(16'hFFFF, 16'd1, 16'd0);
      send_item(4'h5, 1'b1);
      send_item(4'hA, 1'b0);
      send_item(4'h0, 1'b1);

      // zero writes to edges per turn and diameter are ignored, the spare
      // index changes nothing, the period keeps only its low ten bits
      drain();
      write_reg(REG_EDGES_PER_TURN, 16'd0);
      write_reg(REG_WHEEL_DIAMETER_MM, 16'd0);
      write_reg(REG_SPARE, 16'hFFFF);
      write_reg(REG_WINDOW_PERIOD_MS, 16'hFC03);
      csr_we <= 1'b0;
      send_item(4'hF, 1'b1);
      send_item(4'h0, 1'b1);
      send_item(4'hF, 1'b1);

      // period lowered mid-window: closes on the next item with the full span
      configure(16'd20, 16'd300, 16'd20);
      for (i = 0; i < 8; i++) send_item(i[0] ? 4'h0 : 4'hF, 1'b1);
      drain();
      write_reg(REG_WINDOW_PERIOD_MS, 16'd5);
      csr_we <= 1'b0;
      send_item(4'h3, 1'b0);

      // ---------------- random part ----------------
      // short periods and frequent ticks so that windows close often
      base_items   = items_sent;
      base_batches = batches_seen;
      phase        = 0;
      lv           = 4'h0;
      while (items_sent < base_items + RANDOM_ITEMS ||
             batches_seen < base_batches + RANDOM_BATCHES) begin
         idle_odds = (phase % 3 == 2) ? 0 : $urandom_range(2, 8);
         configure(pick_word(), pick_word(), 16'($urandom_range(0, 6)));
         tick_odds = $urandom_range(1, 3);
         repeat (40) begin
            // sometimes hold the lines so that no edge is seen
            if ($urandom_range(0, 3) != 0) lv = 4'($urandom_range(0, 15));
            send_item(lv, $urandom_range(0, 3) < tick_odds);
         end
         phase++;
      end

      // last stretch with no idling on either side
      idle_odds = 0;
      configure(pick_word(), pick_word(), 16'($urandom_range(1, 4)));
      repeat (30) begin
         lv = 4'($urandom_range(0, 15));
         send_item(lv, 1'($urandom_range(0, 1)));
      end

      drain();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
